@@ hw/rtl/rcr_pkg.sv @@
// Shared types and constants for the run confidence reassignment block.
package rcr_pkg;

    localparam int PENDING_DEPTH = 32;
    localparam int CNT_W         = $clog2(PENDING_DEPTH + 1);
    localparam int IDX_W         = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;
    localparam int CHAR_W        = 8;
    localparam int CONF_W        = 7;

    localparam logic [CHAR_W-1:0] PAD_CHAR = 8'd42;

    typedef struct packed {
        logic [CHAR_W-1:0] base_char;
        logic [CONF_W-1:0] base_conf;
        logic              read_end;
    } t_in_item;

    typedef struct packed {
        logic [CONF_W-1:0] new_conf;
        logic              end_of_read;
        logic              end_of_burst;
        logic              run_split;
    } t_out_item;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PRE,
        ST_INS,
        ST_POST
    } t_state;

    // Broadcast controls seen by every cell of the row
    typedef struct packed {
        logic              ins;
        logic [CONF_W-1:0] ins_val;
        logic              pop_val;
        logic              pop_pos;
        logic              app;
        logic              app_pad;
    } t_cell_ctl;

    // Contents of one cell: a slot of the sorted list and a slot of the pad pattern
    typedef struct packed {
        logic [CONF_W-1:0] val;
        logic              vld;
        logic              pad;
    } t_cell_st;

endpackage

@@ hw/rtl/rcr_cell.sv @@
// One cell of the row: a sorted confidence slot and a position pad flag.
module rcr_cell import rcr_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cell_ctl i_ctl,
    input  logic      i_app_sel,
    input  logic      i_prev_ge,
    input  t_cell_st  i_prev,
    input  t_cell_st  i_next,
    output t_cell_st  o_st,
    output logic      o_ge
);

    logic [CONF_W-1:0] r_val;
    logic              r_vld;
    logic              r_pad;
    logic              w_ge;

    // This cell keeps its value when it is not below the incoming one
    assign w_ge = r_vld && (r_val >= i_ctl.ins_val);
    assign o_ge = w_ge;
    assign o_st = '{val: r_val, vld: r_vld, pad: r_pad};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_ctl.pop_val) begin
            r_vld <= i_next.vld;
        end else if (i_ctl.ins && !w_ge) begin
            r_vld <= i_prev_ge ? 1'b1 : i_prev.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.pop_val) begin
            r_val <= i_next.val;
        end else if (i_ctl.ins && !w_ge) begin
            // take the new value where the list breaks, else shift down from the neighbour
            r_val <= i_prev_ge ? i_ctl.ins_val : i_prev.val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.pop_pos) begin
            r_pad <= i_next.pad;
        end else if (i_app_sel) begin
            r_pad <= i_ctl.app_pad;
        end
    end

endmodule

@@ hw/rtl/rcr_chain.sv @@
// Row of cells holding the pending positions and the sorted run confidences.
module rcr_chain import rcr_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cell_ctl        i_ctl,
    input  logic [IDX_W-1:0] i_app_idx,
    output t_cell_st         o_head
);

    t_cell_st w_st [PENDING_DEPTH];
    logic     w_ge [PENDING_DEPTH];

    for (genvar g = 0; g < PENDING_DEPTH; g++) begin : g_cell
        t_cell_st w_prev;
        t_cell_st w_next;
        logic     w_prev_ge;
        logic     w_sel;

        if (g == 0) begin : g_first
            assign w_prev    = '0;
            assign w_prev_ge = 1'b1;
        end else begin : g_mid
            assign w_prev    = w_st[g-1];
            assign w_prev_ge = w_ge[g-1];
        end

        if (g == PENDING_DEPTH - 1) begin : g_last
            assign w_next = '0;
        end else begin : g_body
            assign w_next = w_st[g+1];
        end

        assign w_sel = i_ctl.app && (i_app_idx == IDX_W'(g));

        rcr_cell u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_ctl     (i_ctl),
            .i_app_sel (w_sel),
            .i_prev_ge (w_prev_ge),
            .i_prev    (w_prev),
            .i_next    (w_next),
            .o_st      (w_st[g]),
            .o_ge      (w_ge[g])
        );
    end

    assign o_head = w_st[0];

endmodule

@@ hw/rtl/run_confidence_reassign_top.sv @@
// Top level of the run confidence reassignment block.
//
// Input channel (i_in_valid / o_in_ready / i_in_data) takes one read position per
// request: base character, confidence and a read-end flag. Output channel
// (o_out_valid / i_out_ready / o_out_data) gives reassigned confidences in
// position order with end-of-read, end-of-burst and split flags, one per cycle
// while the receiver is ready. A position is taken in ST_IDLE and placed into
// the cell row in ST_INS, after a release of the old run in ST_PRE when it closes
// a run. During a release the head cell yields one position a cycle while the
// output register can take it; a read end or a full store releases in ST_POST.
// One request is worked on at a time; the next is taken while the last result
// still sits in the output register. When the receiver stalls, the release
// holds with the output register full, and no new request is taken until the
// release is done. Synchronous reset clears the row's valid bits, the counters
// and the run state; the block is ready as soon as reset is released.
module run_confidence_reassign_top import rcr_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_data
);

    t_state            r_state, n_state;
    t_in_item          r_item, n_item;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [CNT_W-1:0]  r_lim, n_lim;
    logic [CNT_W-1:0]  r_rem, n_rem;
    logic [CHAR_W-1:0] r_run_base, n_run_base;
    logic              r_run_open, n_run_open;
    logic [CONF_W-1:0] r_left, n_left;
    logic              r_split, n_split;
    logic              r_rel_split, n_rel_split;
    logic              r_rel_last, n_rel_last;
    logic              r_rel_eor, n_rel_eor;
    logic              r_out_valid, n_out_valid;
    t_out_item         r_out, n_out;

    t_cell_ctl         w_ctl;
    t_cell_st          w_head;
    logic              w_in_pad, w_pre, w_post, w_emit, w_item_pad, w_last_pos;
    logic [CNT_W-1:0]  w_cnt_pre, w_cnt_new, w_lim_new;
    logic [CONF_W-1:0] w_right, w_conf;
    logic [CONF_W:0]   w_sum;

    rcr_chain u_chain (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (w_ctl),
        .i_app_idx (r_count[IDX_W-1:0]),
        .o_head    (w_head)
    );

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    assign w_in_pad   = (i_in_data.base_char == PAD_CHAR);
    assign w_item_pad = (r_item.base_char == PAD_CHAR);
    assign w_pre      = !w_in_pad && r_run_open && (i_in_data.base_char != r_run_base);
    assign w_cnt_pre  = w_pre ? (r_count - r_lim) : r_count;
    assign w_post     = i_in_data.read_end || (w_cnt_pre == CNT_W'(PENDING_DEPTH - 1));
    assign w_cnt_new  = r_count + CNT_W'(1);
    assign w_lim_new  = w_item_pad ? r_lim : w_cnt_new;

    // Pad value: mean of last released base and the next sorted one, zero past the end
    assign w_right    = w_head.vld ? w_head.val : '0;
    assign w_sum      = {1'b0, r_left} + {1'b0, w_right};
    assign w_conf     = w_head.pad ? w_sum[CONF_W:1] : w_head.val;
    assign w_last_pos = (r_rem == CNT_W'(1));

    assign w_emit = ((r_state == ST_PRE) || (r_state == ST_POST))
                    && (!r_out_valid || i_out_ready);

    always_comb begin
        w_ctl.ins     = (r_state == ST_INS) && !w_item_pad;
        w_ctl.ins_val = r_item.base_conf;
        w_ctl.pop_val = w_emit && !w_head.pad;
        w_ctl.pop_pos = w_emit;
        w_ctl.app     = (r_state == ST_INS);
        w_ctl.app_pad = w_item_pad;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_item      = r_item;
        n_count     = r_count;
        n_lim       = r_lim;
        n_rem       = r_rem;
        n_run_base  = r_run_base;
        n_run_open  = r_run_open;
        n_left      = r_left;
        n_split     = r_split;
        n_rel_split = r_rel_split;
        n_rel_last  = r_rel_last;
        n_rel_eor   = r_rel_eor;
        n_out_valid = r_out_valid;
        n_out       = r_out;

        if (i_out_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_item  = i_in_data;
                    n_state = ST_INS;
                    if (!w_in_pad) begin
                        n_run_base = i_in_data.base_char;
                        n_run_open = 1'b1;
                    end
                    if (w_pre) begin
                        // close the old run: release up to its last base
                        n_rel_split = r_split;
                        n_split     = 1'b0;
                        n_rel_last  = !w_post;
                        n_rel_eor   = 1'b0;
                        n_rem       = r_lim;
                        n_lim       = '0;
                        if (r_lim != '0) begin
                            n_state = ST_PRE;
                        end
                    end
                end
            end
            ST_PRE, ST_POST: begin
                if (w_emit) begin
                    n_out_valid       = 1'b1;
                    n_out.new_conf    = w_conf;
                    n_out.end_of_read = r_rel_eor && w_last_pos;
                    n_out.end_of_burst = r_rel_last && w_last_pos;
                    n_out.run_split   = r_rel_split;
                    n_rem             = r_rem - CNT_W'(1);
                    n_count           = r_count - CNT_W'(1);
                    if (!w_head.pad) begin
                        n_left = w_head.val;
                    end
                    if (w_last_pos) begin
                        if (r_state == ST_PRE) begin
                            n_state = ST_INS;
                        end else begin
                            n_state = ST_IDLE;
                            if (r_rel_eor) begin
                                // drop all read state
                                n_count    = '0;
                                n_lim      = '0;
                                n_run_base = '0;
                                n_run_open = 1'b0;
                                n_left     = '0;
                                n_split    = 1'b0;
                            end
                        end
                    end
                end
            end
            ST_INS: begin
                n_count = w_cnt_new;
                n_lim   = w_lim_new;
                n_state = ST_IDLE;
                if (r_item.read_end) begin
                    n_rem       = w_cnt_new;
                    n_rel_split = r_split;
                    n_rel_last  = 1'b1;
                    n_rel_eor   = 1'b1;
                    n_lim       = '0;
                    n_state     = ST_POST;
                end else if (w_cnt_new == CNT_W'(PENDING_DEPTH)) begin
                    // store full: cut the run after its last base, or flush pads
                    n_rem       = (w_lim_new != '0) ? w_lim_new : w_cnt_new;
                    n_rel_split = 1'b1;
                    n_rel_last  = 1'b1;
                    n_rel_eor   = 1'b0;
                    n_lim       = '0;
                    if (w_lim_new != '0) begin
                        n_split = 1'b1;
                    end
                    n_state     = ST_POST;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_lim       <= '0;
            r_rem       <= '0;
            r_run_base  <= '0;
            r_run_open  <= 1'b0;
            r_left      <= '0;
            r_split     <= 1'b0;
            r_rel_split <= 1'b0;
            r_rel_last  <= 1'b0;
            r_rel_eor   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_count     <= n_count;
            r_lim       <= n_lim;
            r_rem       <= n_rem;
            r_run_base  <= n_run_base;
            r_run_open  <= n_run_open;
            r_left      <= n_left;
            r_split     <= n_split;
            r_rel_split <= n_rel_split;
            r_rel_last  <= n_rel_last;
            r_rel_eor   <= n_rel_eor;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_item <= n_item;
        r_out  <= n_out;
    end

endmodule

@@ bench/tb_run_confidence_reassign_top.sv @@
// Self-checking bench for the run confidence reassignment block: directed table, then random reads.
module tb_run_confidence_reassign_top;
    import rcr_pkg::*;

    localparam logic [CHAR_W-1:0] CH_A = 8'h41;
    localparam logic [CHAR_W-1:0] CH_C = 8'h43;
    localparam logic [CHAR_W-1:0] CH_G = 8'h47;
    localparam logic [CHAR_W-1:0] CH_T = 8'h54;
    localparam logic [CHAR_W-1:0] CH_N = 8'h4E;

    localparam int SCRIPT_LEN   = 23;
    localparam int RANDOM_ITEMS = 115;
    localparam int STALL_LIMIT  = 1000;
    localparam int DRAIN_CYCLES = PENDING_DEPTH + 8;

    typedef struct packed {
        t_in_item  pos;
        logic      typed;
        t_out_item want;
    } t_script_row;

    typedef enum int {
        RD_PLAIN,
        RD_LONG_RUN,
        RD_PAD_FLOOD,
        RD_NOISE
    } t_read_kind;

    typedef enum int {
        RX_OPEN,
        RX_BUSY,
        RX_SPARSE,
        RX_COMB
    } t_rx_mode;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    logic      in_ready;
    t_in_item  in_data   = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    t_out_item out_data;

    run_confidence_reassign_top u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data)
    );

    always #2 clk = ~clk;

    // Predictor state: positions not yet released and the open run
    logic [CONF_W-1:0] pend_conf [PENDING_DEPTH];
    logic              pend_pad  [PENDING_DEPTH];
    int                pend_n        = 0;
    logic [CHAR_W-1:0] open_base     = '0;
    logic              run_is_open   = 1'b0;
    logic [CONF_W-1:0] last_conf     = '0;
    logic              split_pending = 1'b0;

    t_out_item burst_buf [2*PENDING_DEPTH];
    int        burst_n;
    t_out_item conf_expect_q [$];

    int          mismatches  = 0;
    int          items_sent  = 0;
    int          burst_left  = 0;
    int          idle_cycles = 0;
    t_script_row script [SCRIPT_LEN];

    // One past the last stored base, or 0 if only pads are stored
    function automatic int bases_end();
        int i;
        i = pend_n;
        while (i > 0 && pend_pad[i-1])
            i--;
        return i;
    endfunction

    // Sort the bases of the first k positions, fill in pads, release them
    function automatic void release_front(int k, logic split);
        int vals [PENDING_DEPTH];
        int rgt  [PENDING_DEPTH];
        int m, i, j, v, nx, lf;
        if (k > pend_n)
            k = pend_n;
        m = 0;
        for (i = 0; i < k; i++) begin
            if (!pend_pad[i]) begin
                vals[m] = pend_conf[i];
                m++;
            end
        end
        for (i = 1; i < m; i++) begin
            v = vals[i];
            j = i;
            while (j > 0 && vals[j-1] < v) begin
                vals[j] = vals[j-1];
                j--;
            end
            vals[j] = v;
        end
        m = 0;
        for (i = 0; i < k; i++) begin
            if (!pend_pad[i]) begin
                pend_conf[i] = CONF_W'(vals[m]);
                m++;
            end
        end
        nx = 0;
        for (i = k - 1; i >= 0; i--) begin
            if (pend_pad[i])
                rgt[i] = nx;
            else
                nx = pend_conf[i];
        end
        lf = last_conf;
        for (i = 0; i < k; i++) begin
            if (pend_pad[i]) begin
                burst_buf[burst_n] = '{CONF_W'((lf + rgt[i]) >> 1), 1'b0, 1'b0, split};
            end else begin
                lf = pend_conf[i];
                burst_buf[burst_n] = '{CONF_W'(lf), 1'b0, 1'b0, split};
            end
            burst_n++;
        end
        last_conf = CONF_W'(lf);
        for (i = 0; i < pend_n - k; i++) begin
            pend_conf[i] = pend_conf[i+k];
            pend_pad[i]  = pend_pad[i+k];
        end
        pend_n -= k;
    endfunction

    function automatic void predict_position(t_in_item p);
        logic pad;
        int   lim;
        pad     = (p.base_char == PAD_CHAR);
        burst_n = 0;
        if (!pad) begin
            if (run_is_open && p.base_char != open_base) begin
                release_front(bases_end(), split_pending);
                split_pending = 1'b0;
            end
            open_base   = p.base_char;
            run_is_open = 1'b1;
        end
        if (pend_n < PENDING_DEPTH) begin
            pend_conf[pend_n] = pad ? '0 : p.base_conf;
            pend_pad[pend_n]  = pad;
            pend_n++;
        end
        if (p.read_end) begin
            release_front(pend_n, split_pending);
            burst_buf[burst_n-1].end_of_read = 1'b1;
            pend_n        = 0;
            open_base     = '0;
            run_is_open   = 1'b0;
            last_conf     = '0;
            split_pending = 1'b0;
        end else if (pend_n >= PENDING_DEPTH) begin
            lim = bases_end();
            if (lim > 0) begin
                split_pending = 1'b1;
                release_front(lim, 1'b1);
            end else begin
                release_front(pend_n, 1'b1);
            end
        end
        if (burst_n > 0)
            burst_buf[burst_n-1].end_of_burst = 1'b1;
    endfunction

    function automatic t_script_row row(logic [CHAR_W-1:0] ch, int conf, bit last,
                                        bit typed, int want);
        return '{'{ch, CONF_W'(conf), last}, typed, '{CONF_W'(want), 1'b1, 1'b1, 1'b0}};
    endfunction

    function automatic logic [CHAR_W-1:0] pick_base();
        logic [CHAR_W-1:0] b;
        case ($urandom_range(0, 7))
            0: b = CH_A;
            1: b = CH_C;
            2: b = CH_G;
            3, 4: b = CH_T;
            5: b = CH_A;
            6: b = CH_C;
            default: begin
                b = CHAR_W'($urandom);
                if (b == PAD_CHAR)
                    b = CH_N;
            end
        endcase
        return b;
    endfunction

    function automatic logic [CONF_W-1:0] pick_conf();
        case ($urandom_range(0, 15))
            0: return '0;
            1: return '1;
            default: return CONF_W'($urandom);
        endcase
    endfunction

    // Offer one request in bursts with gaps; predict once it is taken
    task automatic send_position(t_in_item it, logic typed, t_out_item want);
        int gap;
        @(negedge clk);
        if (burst_left == 0) begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            burst_left = $urandom_range(1, 16);
            if (gap > 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        in_data  <= it;
        do
            @(posedge clk);
        while (!in_ready);
        items_sent++;
        predict_position(it);
        if (typed) begin
            conf_expect_q.push_back(want);
        end else begin
            for (int i = 0; i < burst_n; i++)
                conf_expect_q.push_back(burst_buf[i]);
        end
    endtask

    task automatic send_random_read(t_read_kind kind);
        t_in_item          read_q [$];
        t_in_item          it;
        logic [CHAR_W-1:0] b;
        int                nruns, len;
        case (kind)
            RD_PLAIN: begin
                nruns = $urandom_range(1, 6);
                repeat (nruns) begin
                    b   = pick_base();
                    len = $urandom_range(1, 5);
                    repeat (len) begin
                        if ($urandom_range(0, 3) == 0)
                            read_q.push_back('{PAD_CHAR, CONF_W'($urandom), 1'b0});
                        else
                            read_q.push_back('{b, pick_conf(), 1'b0});
                    end
                end
            end
            RD_LONG_RUN: begin
                b   = pick_base();
                len = $urandom_range(32, 48);
                repeat (len) begin
                    if ($urandom_range(0, 5) == 0)
                        read_q.push_back('{PAD_CHAR, CONF_W'($urandom), 1'b0});
                    else
                        read_q.push_back('{b, pick_conf(), 1'b0});
                end
                if ($urandom_range(0, 1) == 1) begin
                    b = (b == CH_G) ? CH_C : CH_G;
                    repeat ($urandom_range(1, 3))
                        read_q.push_back('{b, pick_conf(), 1'b0});
                end
            end
            RD_PAD_FLOOD: begin
                if ($urandom_range(0, 1) == 1)
                    read_q.push_back('{pick_base(), pick_conf(), 1'b0});
                len = $urandom_range(32, 45);
                repeat (len)
                    read_q.push_back('{PAD_CHAR, CONF_W'($urandom), 1'b0});
                if ($urandom_range(0, 1) == 1)
                    read_q.push_back('{pick_base(), pick_conf(), 1'b0});
            end
            default: begin
                len = $urandom_range(1, 10);
                repeat (len)
                    read_q.push_back('{CHAR_W'($urandom), CONF_W'($urandom), 1'b0});
            end
        endcase
        foreach (read_q[i]) begin
            it          = read_q[i];
            it.read_end = (i == read_q.size() - 1);
            send_position(it, 1'b0, '0);
        end
    endtask

    // Receiver: switch at random between stall patterns
    t_rx_mode rx_mode  = RX_OPEN;
    int       rx_left  = 0;
    int       rx_cycle = 0;

    always @(negedge clk) begin
        if (rx_left == 0) begin
            rx_mode = t_rx_mode'($urandom_range(0, 3));
            rx_left = $urandom_range(8, 40);
        end
        rx_left--;
        rx_cycle++;
        case (rx_mode)
            RX_OPEN:   out_ready <= 1'b1;
            RX_BUSY:   out_ready <= ($urandom_range(0, 3) != 0);
            RX_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
            default:   out_ready <= (rx_cycle % 5 != 0);
        endcase
    end

    always @(posedge clk) begin
        t_out_item want;
        if (rst_n && out_valid && out_ready) begin
            if (conf_expect_q.size() == 0) begin
                $display("%0t: unexpected result: conf %0d eor %0b eob %0b split %0b",
                         $time, out_data.new_conf, out_data.end_of_read,
                         out_data.end_of_burst, out_data.run_split);
                mismatches++;
            end else begin
                want = conf_expect_q.pop_front();
                if (out_data.new_conf !== want.new_conf
                        || out_data.end_of_read !== want.end_of_read
                        || out_data.end_of_burst !== want.end_of_burst
                        || out_data.run_split !== want.run_split) begin
                    $display("%0t: mismatch exp %0d %0b %0b %0b got %0d %0b %0b %0b",
                             $time, want.new_conf, want.end_of_read, want.end_of_burst,
                             want.run_split, out_data.new_conf, out_data.end_of_read,
                             out_data.end_of_burst, out_data.run_split);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin
        int         n_reads;
        int         pick;
        t_read_kind kind;
        script = '{
            row(CH_A, 127, 1'b1, 1'b1, 127),
            row(PAD_CHAR, 99, 1'b1, 1'b1, 0),
            row(8'h00, 0, 1'b1, 1'b1, 0),
            row(8'hFF, 127, 1'b1, 1'b1, 127),
            row(CH_G, 5, 1'b0, 1'b0, 0),
            row(CH_G, 90, 1'b0, 1'b0, 0),
            row(PAD_CHAR, 77, 1'b0, 1'b0, 0),
            row(CH_G, 40, 1'b0, 1'b0, 0),
            row(PAD_CHAR, 0, 1'b0, 1'b0, 0),
            row(CH_T, 12, 1'b0, 1'b0, 0),
            row(CH_T, 127, 1'b0, 1'b0, 0),
            row(PAD_CHAR, 127, 1'b0, 1'b0, 0),
            row(PAD_CHAR, 1, 1'b0, 1'b0, 0),
            row(CH_C, 0, 1'b0, 1'b0, 0),
            row(8'h2B, 3, 1'b1, 1'b0, 0),
            row(PAD_CHAR, 0, 1'b0, 1'b0, 0),
            row(PAD_CHAR, 0, 1'b0, 1'b0, 0),
            row(CH_A, 100, 1'b0, 1'b0, 0),
            row(CH_A, 0, 1'b0, 1'b0, 0),
            row(PAD_CHAR, 55, 1'b1, 1'b0, 0),
            row(8'hAA, 85, 1'b0, 1'b0, 0),
            row(8'h55, 42, 1'b0, 1'b0, 0),
            row(8'h55, 0, 1'b1, 1'b0, 0)
        };
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (int r = 0; r < SCRIPT_LEN; r++)
            send_position(script[r].pos, script[r].typed, script[r].want);

        // Open with a run overflow and a pad overflow, then mix read shapes
        n_reads = 0;
        while (items_sent < SCRIPT_LEN + RANDOM_ITEMS) begin
            pick = $urandom_range(0, 19);
            if (n_reads == 0)
                kind = RD_LONG_RUN;
            else if (n_reads == 1)
                kind = RD_PAD_FLOOD;
            else if (pick < 11)
                kind = RD_PLAIN;
            else if (pick < 14)
                kind = RD_LONG_RUN;
            else if (pick < 16)
                kind = RD_PAD_FLOOD;
            else
                kind = RD_NOISE;
            send_random_read(kind);
            n_reads++;
        end
        @(negedge clk);
        in_valid <= 1'b0;

        while (conf_expect_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
